// ===== rtl/bcl_pkg.sv =====
// Shared types, register codes and helpers for the block list coalescer.
package bcl_pkg;

    // Largest 63-bit length; lengths and sums saturate here
    localparam logic [62:0] LEN_MAX = {63{1'b1}};

    // APB address width and register word indexes
    localparam int unsigned APB_ADDR_W = 4;
    localparam logic [1:0] REG_ELEMENT_EXTENT   = 2'd0;
    localparam logic [1:0] REG_DISP_IN_BYTES    = 2'd1;
    localparam logic [1:0] REG_LENGTHS_IN_BYTES = 2'd2;

    // One result transaction as it travels down the output pipeline
    typedef struct packed {
        logic [63:0] run_offset;
        logic [62:0] run_length;
        logic [31:0] run_index;
        logic [62:0] total_length;
        logic        is_final;
        logic        is_empty;
    } result_t;

    // Join the two partial products of a 63 x 32 multiply and saturate to 63 bits
    function automatic logic [62:0] sat_combine(input logic [63:0] lo, input logic [63:0] hi);
        logic [95:0] sum;
        begin
            sum = {32'b0, lo} + {hi, 32'b0};
            if (sum[95:63] != 33'b0)
            begin
                sat_combine = LEN_MAX;
            end
            else
            begin
                sat_combine = sum[62:0];
            end
        end
    endfunction

endpackage

// ===== rtl/block_list_coalescer.sv =====
// Block list coalescer: merges adjacent (length, displacement) blocks into byte runs.
// Results pass the s1, s2, s3, pair, m1 and out registers; a pair's second result
// follows its first out of the pair register. Throughput: one pair per cycle while
// results drain and no register access runs, set by the merge compare on the registered
// run end; a pair giving two results holds the pair register until both are handed on.
// Writing element_extent holds item_ready low; the open run end is recomputed with it.
// Reset: rst_n clears all valid flags and list state and returns registers to reset values.
module block_list_coalescer
(
    input  logic                              clk,
    input  logic                              rst_n,
    // pair channel
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic [30:0]                       block_length,
    input  logic signed [63:0]                displacement,
    input  logic                              is_last,
    // result channel
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic signed [63:0]                run_offset,
    output logic [62:0]                       run_length,
    output logic [31:0]                       run_index,
    output logic [62:0]                       total_length,
    output logic                              is_final,
    output logic                              is_empty,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bcl_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    // configuration
    logic [31:0] ext_reg;
    logic        disp_bytes_reg;
    logic        len_bytes_reg;
    logic [63:0] ksat_reg;
    logic [63:0] ksat_next;
    logic        wr_en;
    logic [1:0]  wr_idx;

    // open run end recompute after an extent write
    logic        rc_pend_reg;
    logic        rc_add_reg;
    logic [63:0] rc_plo_reg;
    logic [31:0] rc_phi_reg;
    logic [63:0] rc_plo_next;
    logic [63:0] rc_phi_full;
    logic [31:0] rc_len_hi;

    // list state
    logic        run_open_reg;
    logic [63:0] open_off_reg;
    logic [62:0] open_len_reg;
    logic [63:0] open_end_reg;
    logic [31:0] runs_reg;
    logic [62:0] lsum_reg;
    logic        run_open_next;
    logic [63:0] open_off_next;
    logic [62:0] open_len_next;
    logic [63:0] open_end_next;
    logic [31:0] runs_next;
    logic [62:0] lsum_next;

    // stage 1: input register
    logic        s1_v_reg;
    logic [30:0] s1_blen_reg;
    logic [63:0] s1_disp_reg;
    logic        s1_last_reg;

    // stage 2: products
    logic        s2_v_reg;
    logic [30:0] s2_blen_reg;
    logic [63:0] s2_disp_reg;
    logic        s2_last_reg;
    logic [63:0] s2_plo_reg;
    logic [31:0] s2_phi_reg;
    logic [62:0] s2_pb_reg;
    logic [63:0] s1_plo;
    logic [63:0] s1_phi_full;
    logic [62:0] s1_pb;

    // stage 3: byte offset and byte end of the block
    logic        s3_v_reg;
    logic [30:0] s3_blen_reg;
    logic        s3_last_reg;
    logic [63:0] s3_boff_reg;
    logic [63:0] s3_bend_reg;
    logic [62:0] s3_pb_reg;
    logic [63:0] s2_boff;
    logic [63:0] s2_bend;

    // merge stage
    logic        blk_nz;
    logic        adjacent;
    logic        close_run;
    logic [63:0] len_sum;
    logic [63:0] lsum_sum;
    logic [62:0] lsum_new;
    bcl_pkg::result_t closed_res;
    bcl_pkg::result_t final_res;

    // result pair register
    logic             p0_v_reg;
    logic             p1_v_reg;
    bcl_pkg::result_t p0_reg;
    bcl_pkg::result_t p1_reg;
    logic             p0_v_next;
    logic             p1_v_next;
    bcl_pkg::result_t p0_next;
    bcl_pkg::result_t p1_next;

    // length conversion stages
    logic             m1_v_reg;
    bcl_pkg::result_t m1_res_reg;
    logic [63:0]      m1_len_lo_reg;
    logic [63:0]      m1_len_hi_reg;
    logic [63:0]      m1_tot_lo_reg;
    logic [63:0]      m1_tot_hi_reg;
    logic [31:0]      p0_len_hi;
    logic [31:0]      p0_tot_hi;
    logic             out_v_reg;
    bcl_pkg::result_t out_res_reg;
    bcl_pkg::result_t out_res_next;

    // flow control
    logic out_can;
    logic m1_can;
    logic pop;
    logic pair_free;
    logic c_fire;
    logic s3_can;
    logic s2_can;
    logic s1_can;
    logic item_fire;

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    assign out_can   = !out_v_reg || result_ready;
    assign m1_can    = !m1_v_reg || out_can;
    assign pop       = p0_v_reg && m1_can;
    assign pair_free = !p0_v_reg || (pop && !p1_v_reg);
    assign c_fire    = s3_v_reg && pair_free;
    assign s3_can    = !s3_v_reg || pair_free;
    assign s2_can    = !s2_v_reg || s3_can;
    assign s1_can    = !s1_v_reg || s2_can;
    assign item_ready = s1_can && !psel && !rc_pend_reg && !rc_add_reg;
    assign item_fire  = item_valid && item_ready;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign wr_idx    = paddr[3:2];
    // (2^63 - 1) * extent modulo 2^64, the end offset of a saturated run
    assign ksat_next = {pwdata[0], 63'b0} - {32'b0, pwdata};

    always_comb
    begin
        unique case (paddr[3:2])
            bcl_pkg::REG_ELEMENT_EXTENT:   prdata = ext_reg;
            bcl_pkg::REG_DISP_IN_BYTES:    prdata = {31'b0, disp_bytes_reg};
            bcl_pkg::REG_LENGTHS_IN_BYTES: prdata = {31'b0, len_bytes_reg};
            default:                       prdata = 32'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg        <= 32'd1;
            disp_bytes_reg <= 1'b0;
            len_bytes_reg  <= 1'b0;
            ksat_reg       <= {1'b0, bcl_pkg::LEN_MAX};
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                bcl_pkg::REG_ELEMENT_EXTENT:
                begin
                    ext_reg  <= pwdata;
                    ksat_reg <= ksat_next;
                end
                bcl_pkg::REG_DISP_IN_BYTES:    disp_bytes_reg <= pwdata[0];
                bcl_pkg::REG_LENGTHS_IN_BYTES: len_bytes_reg  <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Run end recompute: open_offset + open_length * extent
    // ------------------------------------------------------------------
    assign rc_len_hi   = {1'b0, open_len_reg[62:32]};
    assign rc_plo_next = open_len_reg[31:0] * ext_reg;
    assign rc_phi_full = rc_len_hi * ext_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_pend_reg <= 1'b0;
            rc_add_reg  <= 1'b0;
        end
        else
        begin
            rc_pend_reg <= wr_en && (wr_idx == bcl_pkg::REG_ELEMENT_EXTENT);
            rc_add_reg  <= rc_pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rc_pend_reg)
        begin
            rc_plo_reg <= rc_plo_next;
            rc_phi_reg <= rc_phi_full[31:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the pair
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (s1_can)
        begin
            s1_v_reg <= item_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_blen_reg <= block_length;
            s1_disp_reg <= displacement;
            s1_last_reg <= is_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: displacement and block length times extent
    // ------------------------------------------------------------------
    assign s1_plo      = s1_disp_reg[31:0] * ext_reg;
    assign s1_phi_full = s1_disp_reg[63:32] * ext_reg;
    assign s1_pb       = s1_blen_reg * ext_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (s2_can)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_can && s1_v_reg)
        begin
            s2_blen_reg <= s1_blen_reg;
            s2_disp_reg <= s1_disp_reg;
            s2_last_reg <= s1_last_reg;
            s2_plo_reg  <= s1_plo;
            s2_phi_reg  <= s1_phi_full[31:0];
            s2_pb_reg   <= s1_pb;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: block byte offset and byte end, modulo 2^64
    // ------------------------------------------------------------------
    assign s2_boff = disp_bytes_reg ? s2_disp_reg : (s2_plo_reg + {s2_phi_reg, 32'b0});
    assign s2_bend = s2_boff + {1'b0, s2_pb_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (s3_can)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_can && s2_v_reg)
        begin
            s3_blen_reg <= s2_blen_reg;
            s3_last_reg <= s2_last_reg;
            s3_boff_reg <= s2_boff;
            s3_bend_reg <= s2_bend;
            s3_pb_reg   <= s2_pb_reg;
        end
    end

    // ------------------------------------------------------------------
    // Merge decision and list state update
    // ------------------------------------------------------------------
    assign blk_nz    = (s3_blen_reg != 31'b0);
    assign adjacent  = blk_nz && run_open_reg && (open_end_reg == s3_boff_reg);
    assign close_run = blk_nz && run_open_reg && !adjacent;
    assign len_sum   = {1'b0, open_len_reg} + {33'b0, s3_blen_reg};
    assign lsum_sum  = {1'b0, lsum_reg} + {33'b0, s3_blen_reg};

    always_comb
    begin
        run_open_next = run_open_reg;
        open_off_next = open_off_reg;
        open_len_next = open_len_reg;
        open_end_next = open_end_reg;
        runs_next     = runs_reg;
        lsum_new      = lsum_reg;

        // merge into the open run, or open a new one
        if (blk_nz)
        begin
            lsum_new = lsum_sum[63] ? bcl_pkg::LEN_MAX : lsum_sum[62:0];
            if (adjacent)
            begin
                if (len_sum[63])
                begin
                    open_len_next = bcl_pkg::LEN_MAX;
                    open_end_next = open_off_reg + ksat_reg;
                end
                else
                begin
                    open_len_next = len_sum[62:0];
                    open_end_next = open_end_reg + {1'b0, s3_pb_reg};
                end
            end
            else
            begin
                run_open_next = 1'b1;
                open_off_next = s3_boff_reg;
                open_len_next = {32'b0, s3_blen_reg};
                open_end_next = s3_bend_reg;
            end
        end
        if (close_run)
        begin
            runs_next = runs_reg + 32'd1;
        end
        lsum_next = lsum_new;

        // closed run and final run as results
        closed_res.run_offset   = open_off_reg;
        closed_res.run_length   = open_len_reg;
        closed_res.run_index    = runs_reg;
        closed_res.total_length = 63'b0;
        closed_res.is_final     = 1'b0;
        closed_res.is_empty     = 1'b0;

        final_res.is_final = 1'b1;
        if (run_open_next)
        begin
            final_res.run_offset   = open_off_next;
            final_res.run_length   = open_len_next;
            final_res.run_index    = runs_next;
            final_res.total_length = lsum_new;
            final_res.is_empty     = 1'b0;
        end
        else
        begin
            final_res.run_offset   = 64'b0;
            final_res.run_length   = 63'b0;
            final_res.run_index    = 32'b0;
            final_res.total_length = 63'b0;
            final_res.is_empty     = 1'b1;
        end

        // end of list: return to the empty state
        if (s3_last_reg)
        begin
            run_open_next = 1'b0;
            open_off_next = 64'b0;
            open_len_next = 63'b0;
            open_end_next = 64'b0;
            runs_next     = 32'b0;
            lsum_next     = 63'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg <= 1'b0;
            open_off_reg <= 64'b0;
            open_len_reg <= 63'b0;
            open_end_reg <= 64'b0;
            runs_reg     <= 32'b0;
            lsum_reg     <= 63'b0;
        end
        else if (rc_add_reg)
        begin
            open_end_reg <= open_off_reg + rc_plo_reg + {rc_phi_reg, 32'b0};
        end
        else if (c_fire)
        begin
            run_open_reg <= run_open_next;
            open_off_reg <= open_off_next;
            open_len_reg <= open_len_next;
            open_end_reg <= open_end_next;
            runs_reg     <= runs_next;
            lsum_reg     <= lsum_next;
        end
    end

    // ------------------------------------------------------------------
    // Result pair: load up to two results, hand them on one at a time
    // ------------------------------------------------------------------
    always_comb
    begin
        p0_v_next = p0_v_reg;
        p1_v_next = p1_v_reg;
        p0_next   = p0_reg;
        p1_next   = p1_reg;
        if (c_fire)
        begin
            p0_v_next = close_run || s3_last_reg;
            p1_v_next = close_run && s3_last_reg;
            p0_next   = close_run ? closed_res : final_res;
            p1_next   = final_res;
        end
        else if (pop)
        begin
            p0_v_next = p1_v_reg;
            p1_v_next = 1'b0;
            p0_next   = p1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_v_reg <= 1'b0;
            p1_v_reg <= 1'b0;
        end
        else
        begin
            p0_v_reg <= p0_v_next;
            p1_v_reg <= p1_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p0_reg <= p0_next;
        p1_reg <= p1_next;
    end

    // ------------------------------------------------------------------
    // Byte lengths: partial products, then join and saturate
    // ------------------------------------------------------------------
    assign p0_len_hi = {1'b0, p0_reg.run_length[62:32]};
    assign p0_tot_hi = {1'b0, p0_reg.total_length[62:32]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg <= 1'b0;
        end
        else if (m1_can)
        begin
            m1_v_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            m1_res_reg    <= p0_reg;
            m1_len_lo_reg <= p0_reg.run_length[31:0] * ext_reg;
            m1_len_hi_reg <= p0_len_hi * ext_reg;
            m1_tot_lo_reg <= p0_reg.total_length[31:0] * ext_reg;
            m1_tot_hi_reg <= p0_tot_hi * ext_reg;
        end
    end

    always_comb
    begin
        out_res_next = m1_res_reg;
        if (len_bytes_reg)
        begin
            out_res_next.run_length   = bcl_pkg::sat_combine(m1_len_lo_reg, m1_len_hi_reg);
            out_res_next.total_length = bcl_pkg::sat_combine(m1_tot_lo_reg, m1_tot_hi_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_can)
        begin
            out_v_reg <= m1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_can && m1_v_reg)
        begin
            out_res_reg <= out_res_next;
        end
    end

    // drive the result ports
    assign result_valid = out_v_reg;
    assign run_offset   = out_res_reg.run_offset;
    assign run_length   = out_res_reg.run_length;
    assign run_index    = out_res_reg.run_index;
    assign total_length = out_res_reg.total_length;
    assign is_final     = out_res_reg.is_final;
    assign is_empty     = out_res_reg.is_empty;

endmodule

// ===== rtl/bcl_checker.sv =====
// Port-level checks for the block list coalescer, bound to the top level.
module bcl_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           item_ready,
    input logic                           result_valid,
    input logic                           result_ready,
    input logic signed [63:0]             run_offset,
    input logic [62:0]                    run_length,
    input logic [31:0]                    run_index,
    input logic [62:0]                    total_length,
    input logic                           is_final,
    input logic                           is_empty,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite
);

    // hold a stalled result transaction
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(run_offset)
            && $stable(run_length) && $stable(run_index) && $stable(is_final))
        else $error("result changed while stalled");

    // an empty result is final, with all fields zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && is_empty |-> is_final && (run_offset == 64'sd0)
            && (run_length == 63'd0) && (run_index == 32'd0) && (total_length == 63'd0))
        else $error("empty result carries data");

    // runs closed before the end of a list carry no total
    a_partial_total: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !is_final |-> (total_length == 63'd0) && !is_empty)
        else $error("non-final result carries total or empty mark");

    // no pair is taken during a register write access
    a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite |-> !item_ready)
        else $error("pair accepted during register write");

endmodule

bind block_list_coalescer bcl_checker u_bcl_checker (.*);

// ===== test/block_list_coalescer_test.sv =====
// Self-checking testbench for the block list coalescer: directed pairs, then random lists.
`timescale 1ns / 1ps

module block_list_coalescer_test;

    localparam int unsigned LIMIT_CYCLES  = 500000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned PHASES        = 10;
    localparam int unsigned PHASE_PAIRS   = 165;

    // Register index with nothing behind it
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    typedef enum logic { ROW_PAIR, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [30:0]       blen;
        logic [63:0]       disp;
        logic              last;
        logic              pinned;
        bcl_pkg::result_t  want;
        logic [1:0]        reg_idx;
    } script_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           item_valid;
    logic                           item_ready;
    logic [30:0]                    block_length;
    logic [63:0]                    displacement;
    logic                           is_last;
    logic                           result_valid;
    logic                           result_ready;
    logic [63:0]                    run_offset;
    logic [62:0]                    run_length;
    logic [31:0]                    run_index;
    logic [62:0]                    total_length;
    logic                           is_final;
    logic                           is_empty;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [bcl_pkg::APB_ADDR_W-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    // Typed expectation travelling with a directed transaction
    logic                  pin_on;
    bcl_pkg::result_t      pin_run;
    bit                    hold_req;

    // Register copies and list state of the predictor
    logic [31:0]           cfg_extent;
    logic                  cfg_disp_bytes;
    logic                  cfg_len_bytes;
    logic                  acc_open;
    logic [63:0]           acc_offset;
    logic [62:0]           acc_length;
    logic [31:0]           acc_runs;
    logic [62:0]           acc_total;
    bcl_pkg::result_t      made_runs [2];

    bcl_pkg::result_t      runs_due [$];
    script_row_t           script [$];

    int unsigned           mismatches;
    int unsigned           pairs_accepted;
    int unsigned           runs_checked;
    int unsigned           lists_closed;
    int unsigned           merges;
    int unsigned           in_stalls;
    int unsigned           reg_writes;
    int unsigned           cycle_count;

    block_list_coalescer dut (.*);

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bcl_pkg::result_t run_of(input logic [63:0] off,
                                                input logic [62:0] len,
                                                input logic [31:0] idx,
                                                input logic [62:0] tot,
                                                input logic fin, input logic emp);
        run_of = {off, len, idx, tot, fin, emp};
    endfunction

    function automatic logic [62:0] sum63(input logic [62:0] a, input logic [30:0] b);
        logic [63:0] s;
        s = {1'b0, a} + {33'b0, b};
        return s[63] ? bcl_pkg::LEN_MAX : s[62:0];
    endfunction

    // Scale an element count to bytes when asked, clamping at the 63-bit ceiling
    function automatic logic [62:0] in_report_units(input logic [62:0] len);
        logic [127:0] p;
        if (!cfg_len_bytes)
            return len;
        p = {65'b0, len} * {96'b0, cfg_extent};
        return (p[127:63] != 0) ? bcl_pkg::LEN_MAX : p[62:0];
    endfunction

    // Advance the run state by one pair; fill made_runs and return how many runs close
    function automatic int coalesce_pair(input logic [30:0] blen, input logic [63:0] disp,
                                         input logic last);
        logic [63:0] start;
        logic [63:0] run_end;
        int n;
        n = 0;
        if (blen != 0)
        begin
            start = cfg_disp_bytes ? disp : disp * {32'b0, cfg_extent};
            run_end = acc_offset + {1'b0, acc_length} * {32'b0, cfg_extent};
            if (acc_open && run_end == start)
            begin
                acc_length = sum63(acc_length, blen);
                merges++;
            end
            else
            begin
                if (acc_open)
                begin
                    made_runs[n] = run_of(acc_offset, in_report_units(acc_length), acc_runs,
                                          '0, 1'b0, 1'b0);
                    n++;
                    acc_runs++;
                end
                acc_open = 1'b1;
                acc_offset = start;
                acc_length = {32'b0, blen};
            end
            acc_total = sum63(acc_total, blen);
        end
        if (last)
        begin
            if (acc_open)
                made_runs[n] = run_of(acc_offset, in_report_units(acc_length), acc_runs,
                                      in_report_units(acc_total), 1'b1, 1'b0);
            else
                made_runs[n] = run_of('0, '0, '0, '0, 1'b1, 1'b1);
            n++;
            lists_closed++;
            acc_open = 1'b0;
            acc_offset = '0;
            acc_length = '0;
            acc_runs = '0;
            acc_total = '0;
        end
        return n;
    endfunction

    task automatic note_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Predict on every accepted pair, check every accepted run
    always @(posedge clk)
    begin : watch
        bcl_pkg::result_t got;
        bcl_pkg::result_t want;
        int n;
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                n = coalesce_pair(block_length, displacement, is_last);
                pairs_accepted++;
                if (pin_on)
                    runs_due.push_back(pin_run);
                else
                    for (int k = 0; k < n; k++)
                        runs_due.push_back(made_runs[k]);
            end
            if (item_valid && !item_ready)
                in_stalls++;
            if (result_valid && result_ready)
            begin
                got = {run_offset, run_length, run_index, total_length, is_final, is_empty};
                if (runs_due.size() == 0)
                begin
                    $display("%0t: run transaction expected none, got offset %h length %h",
                             $time, got.run_offset, got.run_length);
                    mismatches++;
                end
                else
                begin
                    want = runs_due.pop_front();
                    note_field("run_offset", want.run_offset, got.run_offset);
                    note_field("run_length", want.run_length, got.run_length);
                    note_field("run_index", want.run_index, got.run_index);
                    note_field("total_length", want.total_length, got.total_length);
                    note_field("is_final", want.is_final, got.is_final);
                    note_field("is_empty", want.is_empty, got.is_empty);
                    runs_checked++;
                end
            end
        end
    end

    // Guard against a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles with %0d runs outstanding",
                     cycle_count, runs_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: stall in segments of varying density, with one long hold-off on request
    initial
    begin : receiver
        int span;
        int stall_pct;
        result_ready = 1'b0;
        forever
        begin
            span = $urandom_range(1, 48);
            case ($urandom_range(3))
                0: stall_pct = 0;
                1: stall_pct = 30;
                2: stall_pct = 60;
                default: stall_pct = 90;
            endcase
            repeat (span)
            begin
                @(posedge clk);
                if (hold_req)
                begin
                    hold_req = 1'b0;
                    result_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                result_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic void add_pair(input logic [30:0] b, input logic [63:0] d,
                                     input logic l, input logic pin,
                                     input bcl_pkg::result_t w);
        script_row_t r;
        r.kind = ROW_PAIR;
        r.blen = b;
        r.disp = d;
        r.last = l;
        r.pinned = pin;
        r.want = w;
        r.reg_idx = '0;
        script.push_back(r);
    endfunction

    function automatic void add_reg(input logic [1:0] idx, input logic [31:0] val);
        script_row_t r;
        r.kind = ROW_REG;
        r.blen = '0;
        r.disp = {32'b0, val};
        r.last = 1'b0;
        r.pinned = 1'b0;
        r.want = '0;
        r.reg_idx = idx;
        script.push_back(r);
    endfunction

    // Directed rows; typed results only where they are obvious
    function automatic void build_script();
        // empty list straight after reset
        add_pair(31'd0, 64'd0, 1'b1, 1'b1, run_of('0, '0, '0, '0, 1'b1, 1'b1));
        // merge, skip a zero block, then close with two runs
        add_pair(31'd5, 64'd100, 1'b0, 1'b0, '0);
        add_pair(31'd3, 64'd105, 1'b0, 1'b0, '0);
        add_pair(31'd0, 64'd999, 1'b0, 1'b0, '0);
        add_pair(31'd2, 64'd200, 1'b1, 1'b0, '0);
        // widest block at the top of the offset range
        add_pair(31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
                 run_of(64'hFFFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF, '0, 63'h7FFF_FFFF, 1'b1, 1'b0));
        // merge across the sign boundary
        add_pair(31'd1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0);
        add_pair(31'd1, 64'h8000_0000_0000_0000, 1'b1, 1'b0, '0);
        // zero-length last pair still flushes the open run
        add_pair(31'd4, 64'd10, 1'b0, 1'b0, '0);
        add_pair(31'd0, 64'd77, 1'b1, 1'b0, '0);
        // merge across the offset wrap
        add_pair(31'd2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0);
        add_pair(31'd3, 64'd1, 1'b1, 1'b0, '0);
        // byte lengths with the widest extent clamp at the ceiling
        add_reg(bcl_pkg::REG_ELEMENT_EXTENT, 32'hFFFF_FFFF);
        add_reg(bcl_pkg::REG_LENGTHS_IN_BYTES, 32'd1);
        add_pair(31'h7FFF_FFFF, 64'd0, 1'b0, 1'b0, '0);
        add_pair(31'h7FFF_FFFF, 64'h7FFF_FFFF, 1'b1, 1'b1,
                 run_of('0, bcl_pkg::LEN_MAX, '0, bcl_pkg::LEN_MAX, 1'b1, 1'b0));
        // byte displacements
        add_reg(bcl_pkg::REG_DISP_IN_BYTES, 32'd1);
        add_pair(31'd3, 64'h100, 1'b0, 1'b0, '0);
        add_pair(31'd2, 64'h3_0000_00FD, 1'b1, 1'b0, '0);
        // zero extent folds everything into one run at offset zero
        add_reg(bcl_pkg::REG_DISP_IN_BYTES, 32'd0);
        add_reg(bcl_pkg::REG_ELEMENT_EXTENT, 32'd0);
        add_pair(31'd5, 64'd123, 1'b0, 1'b0, '0);
        add_pair(31'd7, 64'hFFFF_FFFF_FFFF_FFF7, 1'b1, 1'b1,
                 run_of('0, '0, '0, '0, 1'b1, 1'b0));
        // a write to an unmapped index changes nothing
        add_reg(REG_UNMAPPED, 32'd5);
        add_pair(31'd1, 64'd5, 1'b1, 1'b0, '0);
    endfunction

    // Present one pair and hold it until the block takes it
    task automatic offer_pair(input logic [30:0] b, input logic [63:0] d, input logic l,
                              input logic pin, input bcl_pkg::result_t w);
        item_valid <= 1'b1;
        block_length <= b;
        displacement <= d;
        is_last <= l;
        pin_on <= pin;
        pin_run <= w;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
    endtask

    task automatic idle_sender(input int gap);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and let every outstanding run drain out of the pipeline
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (runs_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write a register, mirror it in the predictor, then read it back
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] held;
        logic [31:0] mask;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        held = '0;
        mask = '0;
        case (idx)
            bcl_pkg::REG_ELEMENT_EXTENT:
            begin
                cfg_extent = val;
                held = cfg_extent;
                mask = 32'hFFFF_FFFF;
            end
            bcl_pkg::REG_DISP_IN_BYTES:
            begin
                cfg_disp_bytes = val[0];
                held = {31'b0, cfg_disp_bytes};
                mask = 32'd1;
            end
            bcl_pkg::REG_LENGTHS_IN_BYTES:
            begin
                cfg_len_bytes = val[0];
                held = {31'b0, cfg_len_bytes};
                mask = 32'd1;
            end
            default: ;
        endcase
        reg_writes++;
        // read back
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if ((prdata & mask) !== (held & mask))
        begin
            $display("%0t: register %0d read expected %h, got %h", $time, idx, held, prdata);
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        // leave the bus idle
        @(posedge clk);
    endtask

    // Reset, directed rows, then random phases with fresh register settings
    initial
    begin : stimulus
        int burst_left;
        int pick;
        logic [30:0] b;
        logic [63:0] d;
        logic l;
        logic [63:0] gen_next;
        logic [31:0] ext;

        rst_n = 1'b0;
        item_valid = 1'b0;
        block_length = '0;
        displacement = '0;
        is_last = 1'b0;
        pin_on = 1'b0;
        pin_run = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_req = 1'b0;
        cfg_extent = 32'd1;
        cfg_disp_bytes = 1'b0;
        cfg_len_bytes = 1'b0;
        acc_open = 1'b0;
        acc_offset = '0;
        acc_length = '0;
        acc_runs = '0;
        acc_total = '0;
        gen_next = '0;
        build_script();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed part
        foreach (script[i])
        begin
            if (script[i].kind == ROW_REG)
            begin
                settle();
                write_reg(script[i].reg_idx, script[i].disp[31:0]);
            end
            else
            begin
                offer_pair(script[i].blen, script[i].disp, script[i].last,
                           script[i].pinned, script[i].want);
                idle_sender($urandom_range(0, 2));
            end
        end

        // random part
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            case (phase)
                0: ext = 32'd1;
                1: ext = 32'hFFFF_FFFF;
                2: ext = 32'd0;
                default:
                    case ($urandom_range(5))
                        0: ext = 32'd1;
                        1: ext = 32'hFFFF_FFFF;
                        2: ext = 32'd0;
                        3: ext = $urandom_range(2, 16);
                        4: ext = $urandom;
                        default: ext = 32'd4;
                    endcase
            endcase
            write_reg(bcl_pkg::REG_ELEMENT_EXTENT, ext);
            write_reg(bcl_pkg::REG_DISP_IN_BYTES, (phase < 4) ? phase[0] : $urandom_range(1));
            write_reg(bcl_pkg::REG_LENGTHS_IN_BYTES,
                      (phase < 4) ? phase[1] : $urandom_range(1));
            if (phase == 2)
                hold_req = 1'b1;
            burst_left = 0;
            repeat (PHASE_PAIRS)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    idle_sender(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6));
                end
                burst_left--;

                // length: mostly short, some medium, a few across the full field
                pick = $urandom_range(99);
                if (pick < 70)
                    b = 31'($urandom_range(1, 64));
                else if (pick < 90)
                    b = 31'($urandom_range(1, 65535));
                else
                    b = 31'($urandom);
                if ($urandom_range(99) < 10)
                    b = '0;

                // start: mostly where the open run ends, else near it or anywhere
                pick = $urandom_range(99);
                if (pick < 60)
                    d = gen_next;
                else if (pick < 80)
                    d = gen_next + $urandom_range(1, 40);
                else
                    d = {$urandom, $urandom};
                l = ($urandom_range(99) < 8);

                if (b != 0)
                    gen_next = cfg_disp_bytes ? d + {33'b0, b} * {32'b0, cfg_extent}
                                              : d + {33'b0, b};
                offer_pair(b, d, l, 1'b0, '0);
            end
        end

        settle();
        $display("Checked %0d runs from %0d pairs over %0d lists, %0d merges.",
                 runs_checked, pairs_accepted, lists_closed, merges);
        $display("Register writes: %0d; input held back for %0d cycles.",
                 reg_writes, in_stalls);
        if (mismatches == 0 && runs_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
